// File: rtl/core/iamp_pkg.sv
// ----------------------------------------------------------------------------
// iamp_pkg: shared types and constants for the image argmax block
// Holds the limits, sample format codes, register indexes and the payload
// structs that travel between the modules of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iamp_pkg;

  // Image limits.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MAX_BANDS  = 16;

  // Field widths.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned VALUE_W  = 33;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned BAND_W   = 4;
  localparam int unsigned WIDTH_W  = 13;
  localparam int unsigned BANDS_W  = 5;
  localparam int unsigned FMT_W    = 3;
  localparam int unsigned SQ_W     = 31;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd2;

  // Sample formats.
  localparam logic [FMT_W-1:0] FMT_U8      = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S8      = 3'd1;
  localparam logic [FMT_W-1:0] FMT_U16     = 3'd2;
  localparam logic [FMT_W-1:0] FMT_S16     = 3'd3;
  localparam logic [FMT_W-1:0] FMT_U32     = 3'd4;
  localparam logic [FMT_W-1:0] FMT_S32     = 3'd5;
  localparam logic [FMT_W-1:0] FMT_COMPLEX = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_item;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic [POS_W-1:0]          max_x;
    logic [POS_W-1:0]          max_y;
  } out_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] image_width;
    logic [BANDS_W-1:0] band_count;
    logic [FMT_W-1:0]   sample_format;
  } cfg_t;

  // Decoded sample held between the front end and the tracker.
  typedef struct packed {
    logic                      valid;
    logic                      cplx;
    logic signed [VALUE_W-1:0] value;
    logic [SQ_W-1:0]           re_sq;
    logic [SQ_W-1:0]           im_sq;
    logic [POS_W-1:0]          col;
    logic [POS_W-1:0]          row;
    logic                      last_item;
  } stage_t;

endpackage

// File: rtl/core/iamp_front.sv
// ----------------------------------------------------------------------------
// iamp_front: sample decode and raster position counters
// Decodes each accepted sample for the configured format, tags it with its
// pixel column and row, and holds the result in the stage register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iamp_front (
  input  logic             clk,
  input  logic             rst,
  input  iamp_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  iamp_pkg::in_t    in_data,
  input  logic             consume,
  output iamp_pkg::stage_t stage
);
  import iamp_pkg::*;

  logic [BAND_W-1:0]  band_index;
  logic [POS_W-1:0]   column_index;
  logic [POS_W-1:0]   row_index;
  logic [BAND_W-1:0]  band_index_next;
  logic [POS_W-1:0]   column_index_next;
  logic [POS_W-1:0]   row_index_next;
  logic [BANDS_W-1:0] bands;
  logic [WIDTH_W-1:0] width;
  logic [BANDS_W-1:0] band_inc;
  logic [WIDTH_W-1:0] col_inc;
  logic [WIDTH_W-1:0] row_inc;
  logic               in_accept;

  logic signed [VALUE_W-1:0] dec_value;
  logic signed [15:0]        re;
  logic signed [15:0]        im;
  logic signed [31:0]        re_prod;
  logic signed [31:0]        im_prod;

  assign in_ready  = !stage.valid || consume;
  assign in_accept = in_valid && in_ready;

  // Zero bounds count as one; oversized bounds saturate.
  always_comb begin
    if (cfg.band_count == '0) begin
      bands = BANDS_W'(1);
    end else if (cfg.band_count > BANDS_W'(MAX_BANDS)) begin
      bands = BANDS_W'(MAX_BANDS);
    end else begin
      bands = cfg.band_count;
    end
    if (cfg.image_width == '0) begin
      width = WIDTH_W'(1);
    end else if (cfg.image_width > WIDTH_W'(MAX_WIDTH)) begin
      width = WIDTH_W'(MAX_WIDTH);
    end else begin
      width = cfg.image_width;
    end
  end

  always_comb begin
    band_inc          = {1'b0, band_index} + BANDS_W'(1);
    col_inc           = {1'b0, column_index} + WIDTH_W'(1);
    row_inc           = {1'b0, row_index} + WIDTH_W'(1);
    band_index_next   = band_inc[BAND_W-1:0];
    column_index_next = column_index;
    row_index_next    = row_index;
    if (band_inc >= bands) begin
      band_index_next   = '0;
      column_index_next = col_inc[POS_W-1:0];
      if (col_inc >= width) begin
        column_index_next = '0;
        row_index_next    = row_inc[POS_W-1:0];
        if (row_inc >= WIDTH_W'(MAX_HEIGHT)) begin
          row_index_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_index   <= '0;
      column_index <= '0;
      row_index    <= '0;
    end else if (in_accept) begin
      if (in_data.last_item) begin
        band_index   <= '0;
        column_index <= '0;
        row_index    <= '0;
      end else begin
        band_index   <= band_index_next;
        column_index <= column_index_next;
        row_index    <= row_index_next;
      end
    end
  end

  always_comb begin
    re      = in_data.sample[15:0];
    im      = in_data.sample[31:16];
    re_prod = re * re;
    im_prod = im * im;
    case (cfg.sample_format)
      FMT_U8:  dec_value = {25'b0, in_data.sample[7:0]};
      FMT_S8:  dec_value = {{25{in_data.sample[7]}}, in_data.sample[7:0]};
      FMT_U16: dec_value = {17'b0, in_data.sample[15:0]};
      FMT_S16: dec_value = {{17{in_data.sample[15]}}, in_data.sample[15:0]};
      FMT_S32: dec_value = {in_data.sample[31], in_data.sample};
      default: dec_value = {1'b0, in_data.sample};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_accept) begin
      stage.valid <= 1'b1;
    end else if (consume) begin
      stage.valid <= 1'b0;
    end
    if (in_accept) begin
      stage.cplx      <= (cfg.sample_format == FMT_COMPLEX);
      stage.value     <= dec_value;
      stage.re_sq     <= re_prod[SQ_W-1:0];
      stage.im_sq     <= im_prod[SQ_W-1:0];
      stage.col       <= column_index;
      stage.row       <= row_index;
      stage.last_item <= in_data.last_item;
    end
  end

endmodule

// File: rtl/core/iamp_track.sv
// ----------------------------------------------------------------------------
// iamp_track: running maximum and result register
// Compares each decoded sample against the best value so far, keeps the
// first position of the maximum and issues the result on the last sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iamp_track (
  input  logic             clk,
  input  logic             rst,
  input  iamp_pkg::stage_t stage,
  output logic             consume,
  output logic             out_valid,
  input  logic             out_ready,
  output iamp_pkg::out_t   out_data
);
  import iamp_pkg::*;

  logic signed [VALUE_W-1:0] best_value;
  logic [POS_W-1:0]          best_column;
  logic [POS_W-1:0]          best_row;
  logic                      first_pending;

  logic [SQ_W:0]             mod_sum;
  logic signed [VALUE_W-1:0] cand;
  logic                      take;
  logic signed [VALUE_W-1:0] best_value_next;
  logic [POS_W-1:0]          best_column_next;
  logic [POS_W-1:0]          best_row_next;

  // A last sample waits only while an earlier result is still unclaimed.
  assign consume = stage.valid && (!stage.last_item || !out_valid || out_ready);

  always_comb begin
    mod_sum = {1'b0, stage.re_sq} + {1'b0, stage.im_sq};
    cand    = stage.cplx ? {1'b0, mod_sum} : stage.value;
    take    = first_pending || (cand > best_value);
    best_value_next  = take ? cand : best_value;
    best_column_next = take ? stage.col : best_column;
    best_row_next    = take ? stage.row : best_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value    <= '0;
      best_column   <= '0;
      best_row      <= '0;
      first_pending <= 1'b1;
    end else if (consume) begin
      if (stage.last_item) begin
        best_value    <= '0;
        best_column   <= '0;
        best_row      <= '0;
        first_pending <= 1'b1;
      end else begin
        best_value    <= best_value_next;
        best_column   <= best_column_next;
        best_row      <= best_row_next;
        first_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && stage.last_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && stage.last_item) begin
      out_data.max_value <= best_value_next;
      out_data.max_x     <= best_column_next;
      out_data.max_y     <= best_row_next;
    end
  end

endmodule

// File: rtl/core/image_argmax_with_position.sv
// ----------------------------------------------------------------------------
// image_argmax_with_position: greatest sample of an image and its position
// A result is registered when its last sample leaves the decode register.
// Throughput: one sample per cycle unless a result waits; the decode
// register and the compare and update register set that rate. A waiting
// result holds the next last sample in the decode register, and the input
// stalls behind it. Reset is synchronous: it empties the pipeline, clears
// the running maximum and counters, and sets width 1, 1 band, format u8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_argmax_with_position (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iamp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iamp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  iamp_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output iamp_pkg::out_t                       out_data
);
  import iamp_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   consume;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= WIDTH_W'(1);
      cfg.band_count    <= BANDS_W'(1);
      cfg.sample_format <= FMT_U8;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[WIDTH_W-1:0];
        REG_BAND_COUNT:    cfg.band_count    <= cfg_data[BANDS_W-1:0];
        REG_SAMPLE_FORMAT: cfg.sample_format <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  iamp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .consume  (consume),
    .stage    (stage)
  );

  iamp_track u_track (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .consume   (consume),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An empty stage register must always take a new transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage.valid |-> in_ready)
    else $error("input not ready while the stage register is empty");

  // Retiring a last sample always leaves a result on the output.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    consume && stage.last_item |=> out_valid)
    else $error("last sample retired without a result");

  // A held sample keeps its position until it is retired.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !consume |=> stage.valid && $stable(stage.col) && $stable(stage.row))
    else $error("stalled sample lost or changed");

  // A last sample is held back only behind an unclaimed result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !consume |-> stage.last_item && out_valid && !out_ready)
    else $error("stage stalled without a waiting result");

endmodule
